/* rtl/srie_pkg.sv */
// Package of the small RISC instruction executor: constants, codes, result type, helpers.
`timescale 1ns / 1ps

package srie_pkg;

  // Storage sizes and reset values.
  localparam int unsigned DATA_WORDS    = 256;
  localparam int unsigned MEM_IDX_W     = 8;
  localparam int unsigned RF_DEPTH      = 32;
  localparam int unsigned RF_AW         = 5;
  localparam logic [31:0] START_ADDRESS = 32'd64;
  localparam logic [31:0] PC_STEP       = 32'd4;
  localparam logic [31:0] DataWordsW    = 32'(DATA_WORDS);

  // Instruction categories, bits 31..29.
  localparam logic [2:0] CAT_CTRL = 3'b001;
  localparam logic [2:0] CAT_REG  = 3'b010;
  localparam logic [2:0] CAT_IMM  = 3'b100;

  // Control category opcodes.
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_J     = 3'd1;
  localparam logic [2:0] OP_BEQ   = 3'd2;
  localparam logic [2:0] OP_BNE   = 3'd3;
  localparam logic [2:0] OP_BGTZ  = 3'd4;
  localparam logic [2:0] OP_SW    = 3'd5;
  localparam logic [2:0] OP_LW    = 3'd6;
  localparam logic [2:0] OP_BREAK = 3'd7;

  // Register category opcodes.
  localparam logic [2:0] OP_XOR  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_AND  = 3'd4;
  localparam logic [2:0] OP_OR   = 3'd5;
  localparam logic [2:0] OP_ADDU = 3'd6;
  localparam logic [2:0] OP_SUBU = 3'd7;

  // Immediate category opcodes.
  localparam logic [2:0] OP_ORI  = 3'd0;
  localparam logic [2:0] OP_XORI = 3'd1;
  localparam logic [2:0] OP_ADDI = 3'd2;
  localparam logic [2:0] OP_SUBI = 3'd3;
  localparam logic [2:0] OP_ANDI = 3'd4;
  localparam logic [2:0] OP_SRL  = 3'd5;
  localparam logic [2:0] OP_SRA  = 3'd6;
  localparam logic [2:0] OP_SLL  = 3'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDEF = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Everything one executed word produces, carried from execute to writeback.
  typedef struct packed {
    logic [31:0]          next_pc;
    logic                 halted;
    logic                 reg_written;
    logic [RF_AW-1:0]     reg_index;
    logic [31:0]          reg_value;
    logic                 mem_written;
    logic [MEM_IDX_W-1:0] mem_index;
    logic [31:0]          mem_value;
    logic                 is_load;
    logic [MEM_IDX_W-1:0] load_addr;
    status_e              status;
  } exec_res_t;

  // First register read address: C for the register category, A otherwise.
  function automatic logic [RF_AW-1:0] rf_x_addr(input logic [31:0] instr);
    rf_x_addr = (instr[31:29] == CAT_REG) ? instr[15:11] : instr[25:21];
  endfunction

  // Sign extension of the 16-bit immediate.
  function automatic logic [31:0] sext16(input logic [15:0] imm);
    sext16 = {{16{imm[15]}}, imm};
  endfunction

endpackage

/* rtl/srie_in_if.sv */
// Input channel of the executor: one instruction or preload word per handshake.
`timescale 1ns / 1ps

interface srie_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic        [31:0] instr;
  logic        [7:0]  load_index;
  logic signed [31:0] load_value;

  modport source (output valid, output func, output instr, output load_index,
                  output load_value, input ready);
  modport sink   (input valid, input func, input instr, input load_index,
                  input load_value, output ready);
endinterface

/* rtl/srie_out_if.sv */
// Output channel of the executor: one result word per handshake.
`timescale 1ns / 1ps

interface srie_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] next_pc;
  logic               halted;
  logic               reg_written;
  logic        [4:0]  reg_index;
  logic signed [31:0] reg_value;
  logic               mem_written;
  logic        [7:0]  mem_index;
  logic signed [31:0] mem_value;
  logic        [1:0]  status;

  modport source (output valid, output next_pc, output halted, output reg_written,
                  output reg_index, output reg_value, output mem_written,
                  output mem_index, output mem_value, output status, input ready);
  modport sink   (input valid, input next_pc, input halted, input reg_written,
                  input reg_index, input reg_value, input mem_written,
                  input mem_index, input mem_value, input status, output ready);
endinterface

/* rtl/srie_regfile.sv */
// Register file: 32 x 32 synchronous memory, two read ports, write bypass, reset-valid bits.
`timescale 1ns / 1ps

module srie_regfile import srie_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [RF_AW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic             re_i,
  input  logic [RF_AW-1:0] raddr_x_i,
  input  logic [RF_AW-1:0] raddr_y_i,
  output logic [31:0]      rdata_x_o,
  output logic [31:0]      rdata_y_o
);

  logic [31:0]         mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid_q;
  logic [31:0]         rdata_x_q;
  logic [31:0]         rdata_y_q;

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Array write and registered reads; a write at the same edge is passed through.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_x_i)) begin
        rdata_x_q <= wdata_i;
      end else begin
        rdata_x_q <= valid_q[raddr_x_i] ? mem[raddr_x_i] : 32'd0;
      end
      if (we_i && (waddr_i == raddr_y_i)) begin
        rdata_y_q <= wdata_i;
      end else begin
        rdata_y_q <= valid_q[raddr_y_i] ? mem[raddr_y_i] : 32'd0;
      end
    end
  end

  assign rdata_x_o = rdata_x_q;
  assign rdata_y_o = rdata_y_q;

endmodule

/* rtl/srie_datamem.sv */
// Data memory: DATA_WORDS x 32 synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps

module srie_datamem import srie_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [MEM_IDX_W-1:0] waddr_i,
  input  logic [31:0]          wdata_i,
  input  logic                 re_i,
  input  logic [MEM_IDX_W-1:0] raddr_i,
  output logic [31:0]          rdata_o
);

  logic [31:0] mem [DATA_WORDS];
  logic [31:0] rdata_q;

  // The read data holds until the next read, so a stalled load keeps its word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/srie_exec.sv */
// Execute logic: decodes one word and computes next pc, halt, writes and status.
`timescale 1ns / 1ps

module srie_exec import srie_pkg::*; (
  input  logic                 func_i,
  input  logic [31:0]          instr_i,
  input  logic [MEM_IDX_W-1:0] load_index_i,
  input  logic [31:0]          load_value_i,
  input  logic [31:0]          op_x_i,
  input  logic [31:0]          op_y_i,
  input  logic [31:0]          pc_i,
  input  logic                 halt_i,
  input  logic [15:0]          data_base_i,
  output exec_res_t            res_o
);

  logic [2:0]  cat;
  logic [2:0]  op;
  logic [15:0] imm;
  logic [31:0] imm_s;
  logic [4:0]  sa;
  logic [31:0] seq_pc;
  logic [31:0] target;
  logic [31:0] addr_diff;
  logic        addr_bad;
  logic [31:0] alu_r;
  logic [31:0] imm_r;

  assign cat       = instr_i[31:29];
  assign op        = instr_i[28:26];
  assign imm       = instr_i[15:0];
  assign imm_s     = sext16(imm);
  assign sa        = instr_i[4:0];
  assign seq_pc    = pc_i + PC_STEP;
  assign target    = seq_pc + {imm_s[29:0], 2'b00};
  assign addr_diff = op_x_i + imm_s - {16'd0, data_base_i};
  assign addr_bad  = {2'b00, addr_diff[31:2]} >= DataWordsW;

  // Register-register operations.
  always_comb begin
    case (op)
      OP_XOR:            alu_r = op_y_i ^ op_x_i;
      OP_MUL:            alu_r = op_y_i * op_x_i;
      OP_ADD, OP_ADDU:   alu_r = op_y_i + op_x_i;
      OP_SUB, OP_SUBU:   alu_r = op_y_i - op_x_i;
      OP_AND:            alu_r = op_y_i & op_x_i;
      default:           alu_r = op_y_i | op_x_i;
    endcase
  end

  // Register-immediate operations and shifts.
  always_comb begin
    case (op)
      OP_ORI:  imm_r = op_y_i | {16'd0, imm};
      OP_XORI: imm_r = op_y_i ^ {16'd0, imm};
      OP_ADDI: imm_r = op_y_i + imm_s;
      OP_SUBI: imm_r = op_y_i - imm_s;
      OP_ANDI: imm_r = op_y_i & {16'd0, imm};
      OP_SRL:  imm_r = op_y_i >> sa;
      OP_SRA:  imm_r = 32'($signed(op_y_i) >>> sa);
      default: imm_r = op_y_i << sa;
    endcase
  end

  // Decode and result assembly.
  always_comb begin
    res_o             = '0;
    res_o.next_pc     = pc_i;
    res_o.halted      = halt_i;
    res_o.status      = STATUS_OK;
    if (func_i) begin
      // Preload of one data word; the pc does not move.
      if ({{(32-MEM_IDX_W){1'b0}}, load_index_i} < DataWordsW) begin
        res_o.mem_written = 1'b1;
        res_o.mem_index   = load_index_i;
        res_o.mem_value   = load_value_i;
      end else begin
        res_o.status = STATUS_RANGE;
      end
    end else if (!halt_i) begin
      res_o.next_pc = seq_pc;
      case (cat)
        CAT_CTRL: begin
          case (op)
            OP_NOP: begin
            end
            OP_J: begin
              res_o.next_pc = {seq_pc[31:28], instr_i[25:0], 2'b00};
            end
            OP_BEQ: begin
              if (op_x_i == op_y_i) res_o.next_pc = target;
            end
            OP_BNE: begin
              if (op_x_i != op_y_i) res_o.next_pc = target;
            end
            OP_BGTZ: begin
              if ((op_x_i != 32'd0) && !op_x_i[31]) res_o.next_pc = target;
            end
            OP_SW, OP_LW: begin
              if (addr_bad) begin
                res_o.status = STATUS_RANGE;
              end else if (op == OP_SW) begin
                res_o.mem_written = 1'b1;
                res_o.mem_index   = addr_diff[MEM_IDX_W+1:2];
                res_o.mem_value   = op_y_i;
              end else begin
                // The loaded word arrives from the data memory in writeback.
                res_o.is_load     = 1'b1;
                res_o.load_addr   = addr_diff[MEM_IDX_W+1:2];
                res_o.reg_written = 1'b1;
                res_o.reg_index   = instr_i[20:16];
              end
            end
            default: begin
              res_o.halted = 1'b1;
            end
          endcase
        end
        CAT_REG: begin
          res_o.reg_written = 1'b1;
          res_o.reg_index   = instr_i[25:21];
          res_o.reg_value   = alu_r;
        end
        CAT_IMM: begin
          res_o.reg_written = 1'b1;
          res_o.reg_index   = instr_i[25:21];
          res_o.reg_value   = imm_r;
        end
        default: begin
          res_o.status = STATUS_UNDEF;
        end
      endcase
    end
  end

endmodule

/* rtl/small_risc_instruction_executor_top.sv */
// Top level of the small RISC instruction executor: two-stage pipeline around two memories.
//
//   channel   direction  handshake          contents
//   in_i      sink       valid/ready        func, instr, load_index, load_value
//   out_o     source     valid/ready        next_pc, halted, reg and mem writes, status
//   cfg       input      cfg_we_i           data_base (cfg_wdata_i, 16 bits)
//
// A word is accepted every cycle while results are taken. The register file is read at
// the accepting edge and the word is then executed; the data memory is read as it leaves
// execute, and the result is offered from the writeback register.
// Register writes retire in writeback and are forwarded to execute.
// Reset clears the pc to 64, the halt flag, data_base and the register valid bits at once.
// A stalled output holds writeback and execute; input ready drops only when both stages
// are full and the output is stalled.
`timescale 1ns / 1ps

module small_risc_instruction_executor_top import srie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  srie_in_if.sink     in_i,
  srie_out_if.source  out_o
);

  logic [15:0]          data_base_q;
  logic [31:0]          pc_q;
  logic                 halt_q;
  logic                 e_valid_q, e_valid_d;
  logic                 e_func_q;
  logic [31:0]          e_instr_q;
  logic [MEM_IDX_W-1:0] e_lidx_q;
  logic [31:0]          e_lval_q;
  logic                 w_valid_q, w_valid_d;
  exec_res_t            w_res_q;
  exec_res_t            e_res;

  logic                 in_fire;
  logic                 w_fire;
  logic                 w_free;
  logic                 e_adv;
  logic [31:0]          rf_rdata_x;
  logic [31:0]          rf_rdata_y;
  logic [31:0]          dm_rdata;
  logic                 w_pending;
  logic [31:0]          w_wdata;
  logic [RF_AW-1:0]     e_xaddr;
  logic [RF_AW-1:0]     e_yaddr;
  logic [31:0]          op_x;
  logic [31:0]          op_y;

  // Pipeline handshake.
  assign w_fire      = w_valid_q & out_o.ready;
  assign w_free      = ~w_valid_q | out_o.ready;
  assign e_adv       = e_valid_q & w_free;
  assign in_i.ready  = ~e_valid_q | w_free;
  assign in_fire     = in_i.valid & in_i.ready;

  always_comb begin
    e_valid_d = e_valid_q;
    if (in_fire) begin
      e_valid_d = 1'b1;
    end else if (e_adv) begin
      e_valid_d = 1'b0;
    end
  end

  always_comb begin
    w_valid_d = w_valid_q;
    if (e_adv) begin
      w_valid_d = 1'b1;
    end else if (w_fire) begin
      w_valid_d = 1'b0;
    end
  end

  // Control state: valid flags, pc, halt flag and the data base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      pc_q        <= START_ADDRESS;
      halt_q      <= 1'b0;
      data_base_q <= '0;
    end else begin
      e_valid_q <= e_valid_d;
      w_valid_q <= w_valid_d;
      if (e_adv) begin
        pc_q   <= e_res.next_pc;
        halt_q <= e_res.halted;
      end
      if (cfg_we_i) begin
        data_base_q <= cfg_wdata_i;
      end
    end
  end

  // Execute and writeback payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_func_q  <= in_i.func;
      e_instr_q <= in_i.instr;
      e_lidx_q  <= in_i.load_index;
      e_lval_q  <= in_i.load_value;
    end
    if (e_adv) begin
      w_res_q <= e_res;
    end
  end

  // Register file, read when a word is accepted and written when its result leaves.
  srie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (w_fire & w_res_q.reg_written),
    .waddr_i   (w_res_q.reg_index),
    .wdata_i   (w_wdata),
    .re_i      (in_fire),
    .raddr_x_i (rf_x_addr(in_i.instr)),
    .raddr_y_i (in_i.instr[20:16]),
    .rdata_x_o (rf_rdata_x),
    .rdata_y_o (rf_rdata_y)
  );

  // Forward the write still held in writeback to the word in execute.
  assign w_pending = w_valid_q & w_res_q.reg_written;
  assign w_wdata   = w_res_q.is_load ? dm_rdata : w_res_q.reg_value;
  assign e_xaddr   = rf_x_addr(e_instr_q);
  assign e_yaddr   = e_instr_q[20:16];
  assign op_x      = (w_pending && (w_res_q.reg_index == e_xaddr)) ? w_wdata : rf_rdata_x;
  assign op_y      = (w_pending && (w_res_q.reg_index == e_yaddr)) ? w_wdata : rf_rdata_y;

  srie_exec u_exec (
    .func_i       (e_func_q),
    .instr_i      (e_instr_q),
    .load_index_i (e_lidx_q),
    .load_value_i (e_lval_q),
    .op_x_i       (op_x),
    .op_y_i       (op_y),
    .pc_i         (pc_q),
    .halt_i       (halt_q),
    .data_base_i  (data_base_q),
    .res_o        (e_res)
  );

  // Data memory, written and read as the word leaves execute.
  srie_datamem u_datamem (
    .clk_i   (clk_i),
    .we_i    (e_adv & e_res.mem_written),
    .waddr_i (e_res.mem_index),
    .wdata_i (e_res.mem_value),
    .re_i    (e_adv & e_res.is_load),
    .raddr_i (e_res.load_addr),
    .rdata_o (dm_rdata)
  );

  // Result word from writeback.
  assign out_o.valid       = w_valid_q;
  assign out_o.next_pc     = w_res_q.next_pc;
  assign out_o.halted      = w_res_q.halted;
  assign out_o.reg_written = w_res_q.reg_written;
  assign out_o.reg_index   = w_res_q.reg_index;
  assign out_o.reg_value   = w_wdata;
  assign out_o.mem_written = w_res_q.mem_written;
  assign out_o.mem_index   = w_res_q.mem_index;
  assign out_o.mem_value   = w_res_q.mem_value;
  assign out_o.status      = w_res_q.status;

endmodule

/* rtl/srie_checker.sv */
// Port-level checker of the executor and its bind to the top level.
`timescale 1ns / 1ps

module srie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] next_pc_i,
  input logic        halted_i,
  input logic        reg_written_i,
  input logic [4:0]  reg_index_i,
  input logic [31:0] reg_value_i,
  input logic        mem_written_i,
  input logic [7:0]  mem_index_i,
  input logic [31:0] mem_value_i,
  input logic [1:0]  status_i
);

  logic seen_halt_q;

  // Remember that a halted result has been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && halted_i) begin
      seen_halt_q <= 1'b1;
    end
  end

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_pc_i) &&
    $stable(reg_value_i) && $stable(mem_value_i) && $stable(status_i))
    else $error("result word changed while stalled");

  // Once halted, every later result reports halted.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_halt_q |-> halted_i)
    else $error("halt flag dropped after BREAK");

  // The fetch address stays word aligned.
  a_pc_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> next_pc_i[1:0] == 2'b00)
    else $error("next pc not word aligned");

  // Fields of a write that did not happen read as zero.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (reg_written_i || (reg_index_i == 5'd0 && reg_value_i == 32'd0)) &&
    (mem_written_i || (mem_index_i == 8'd0 && mem_value_i == 32'd0)))
    else $error("write fields nonzero without a write");

  // Status codes stay in range, and a flagged word writes nothing.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != 2'd0 |-> status_i != 2'd3 && !reg_written_i &&
    !mem_written_i)
    else $error("bad status or write with error status");

endmodule

bind small_risc_instruction_executor_top srie_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .next_pc_i     (out_o.next_pc),
  .halted_i      (out_o.halted),
  .reg_written_i (out_o.reg_written),
  .reg_index_i   (out_o.reg_index),
  .reg_value_i   (out_o.reg_value),
  .mem_written_i (out_o.mem_written),
  .mem_index_i   (out_o.mem_index),
  .mem_value_i   (out_o.mem_value),
  .status_i      (out_o.status)
);
